/* hw/rtl/irs_pkg.sv */
// ----------------------------------------------------------------------------
// irs_pkg
// Shared constants, register indexes and helpers of the image resize sampler.
// ----------------------------------------------------------------------------
package irs_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_CHANNELS = 3;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CH_W   = 2;
  localparam int BANK_DEPTH = MAX_CHANNELS * (MAX_HEIGHT / 2) * (MAX_WIDTH / 2);
  localparam int BANK_AW    = CH_W + (ROW_W - 1) + (COL_W - 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_SRC_WIDTH  = 3'd1,
    REG_SRC_HEIGHT = 3'd2,
    REG_X_STEP     = 3'd3,
    REG_Y_STEP     = 3'd4
  } irs_reg_t;

  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;
  localparam logic MODE_NEAREST  = 1'b0;

  // Saturates a non-negative source index to the last column or row.
  function automatic logic [COL_W-1:0] clamp_idx(input logic [20:0] v,
                                                 input logic [COL_W-1:0] lim);
    logic [COL_W-1:0] r;
    if (v > 21'(lim)) r = lim;
    else r = v[COL_W-1:0];
    return r;
  endfunction

  // Effective image size minus one, saturated into the legal range.
  function automatic logic [COL_W-1:0] last_idx(input logic [8:0] v,
                                                input int unsigned max_v);
    logic [COL_W-1:0] r;
    if (v == 9'd0) r = '0;
    else if (32'(v) > max_v) r = COL_W'(max_v - 1);
    else r = COL_W'(v - 9'd1);
    return r;
  endfunction

endpackage

/* hw/rtl/irs_if.sv */
// ----------------------------------------------------------------------------
// irs_req_if / irs_rsp_if
// Valid/ready channels for sampler requests and output pixels.
// ----------------------------------------------------------------------------
interface irs_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [11:0] coord_x;
  logic [11:0] coord_y;
  logic [1:0]  channel;
  logic [7:0]  pixel_in;

  modport source (output valid, action, coord_x, coord_y, channel, pixel_in,
                  input ready);
  modport sink (input valid, action, coord_x, coord_y, channel, pixel_in,
                output ready);
endinterface

interface irs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink (input valid, pixel_out, output ready);
endinterface

/* hw/rtl/irs_ram.sv */
// ----------------------------------------------------------------------------
// irs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module irs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/image_resize_sampler.sv */
// ----------------------------------------------------------------------------
// image_resize_sampler
// Source image store in four row/column parity banks and a bilinear or
// nearest-neighbor sampler that reads all four neighbors in one access.
// ----------------------------------------------------------------------------
// A request passes the position product, neighbor index, store access, horizontal
// blend and vertical blend registers to its output pixel; a load writes the store in
// the store access stage. Throughput: one request per cycle; the pipeline holds as a
// whole while the output pixel waits.
// Reset clears the pipeline valid bits and the registers to their defaults;
// the image store is not cleared.
module image_resize_sampler
  import irs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  irs_req_if.sink               req,
  irs_rsp_if.source             rsp
);

  logic        mode;
  logic [8:0]  src_width;
  logic [8:0]  src_height;
  logic [23:0] x_step;
  logic [23:0] y_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b1;
      src_width  <= 9'd256;
      src_height <= 9'd256;
      x_step     <= 24'd65536;
      y_step     <= 24'd65536;
    end else if (cfg_we) begin
      unique case (irs_reg_t'(cfg_index))
        REG_MODE:       mode       <= cfg_data[0];
        REG_SRC_WIDTH:  src_width  <= cfg_data[8:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[8:0];
        REG_X_STEP:     x_step     <= cfg_data;
        REG_Y_STEP:     y_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  assign w_last = last_idx(src_width, MAX_WIDTH);
  assign h_last = last_idx(src_height, MAX_HEIGHT);

  logic en;
  logic v1, v2, v3, v4, v5;

  assign en        = !v5 || rsp.ready;
  assign req.ready = en;

  // Stage 1: position products.
  logic        act1;
  logic [1:0]  ch1;
  logic [11:0] lx1, ly1;
  logic [7:0]  px1;
  logic [36:0] prodx1, prody1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1   <= req.action;
      ch1    <= req.channel;
      lx1    <= req.coord_x;
      ly1    <= req.coord_y;
      px1    <= req.pixel_in;
      prodx1 <= 37'({req.coord_x, 1'b1}) * 37'(x_step);
      prody1 <= 37'({req.coord_y, 1'b1}) * 37'(y_step);
    end
  end

  // Stage 2: neighbor indexes and weights.
  logic [37:0] qx, qy;
  logic [20:0] gx, gy;
  logic [COL_W-1:0] x0_c, x1_c;
  logic [ROW_W-1:0] y0_c, y1_c;
  logic [7:0] wx_c, wy_c;

  always_comb begin
    qx = 38'(prodx1) + 38'd65536;
    qy = 38'(prody1) + 38'd65536;
    gx = qx[37:17];
    gy = qy[37:17];
    if (mode == MODE_NEAREST) begin
      x0_c = clamp_idx({1'b0, prodx1[36:17]}, w_last);
      x1_c = x0_c;
      y0_c = clamp_idx({1'b0, prody1[36:17]}, h_last);
      y1_c = y0_c;
      wx_c = '0;
      wy_c = '0;
    end else begin
      x0_c = (gx == '0) ? '0 : clamp_idx(gx - 21'd1, w_last);
      x1_c = clamp_idx(gx, w_last);
      y0_c = (gy == '0) ? '0 : clamp_idx(gy - 21'd1, h_last);
      y1_c = clamp_idx(gy, h_last);
      wx_c = qx[16:9];
      wy_c = qy[16:9];
    end
  end

  logic             act2, lwe2;
  logic [1:0]       ch2;
  logic [COL_W-1:0] x0_2, x1_2, lx2;
  logic [ROW_W-1:0] y0_2, y1_2, ly2;
  logic [7:0]       wx2, wy2, px2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act2 <= act1;
      ch2  <= ch1;
      lwe2 <= (32'(lx1) < MAX_WIDTH) && (32'(ly1) < MAX_HEIGHT)
              && (32'(ch1) < MAX_CHANNELS);
      lx2  <= lx1[COL_W-1:0];
      ly2  <= ly1[ROW_W-1:0];
      px2  <= px1;
      x0_2 <= x0_c;
      x1_2 <= x1_c;
      y0_2 <= y0_c;
      y1_2 <= y1_c;
      wx2  <= wx_c;
      wy2  <= wy_c;
    end
  end

  // Stage 3: store access, one bank per row and column parity.
  logic       load_go;
  logic [1:0] rch;
  logic [7:0] rd [4];

  assign load_go = en && v2 && (act2 == ACTION_LOAD) && lwe2;
  assign rch     = (32'(ch2) < MAX_CHANNELS) ? ch2 : 2'd0;

  for (genvar r = 0; r < 2; r++) begin : g_row
    for (genvar c = 0; c < 2; c++) begin : g_col
      logic [ROW_W-1:0] rrow;
      logic [COL_W-1:0] rcol;
      assign rrow = (y0_2[0] == 1'(r)) ? y0_2 : y1_2;
      assign rcol = (x0_2[0] == 1'(c)) ? x0_2 : x1_2;

      irs_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
      ) u_bank (
        .clk   (clk),
        .we    (load_go && (ly2[0] == 1'(r)) && (lx2[0] == 1'(c))),
        .waddr ({ch2, ly2[ROW_W-1:1], lx2[COL_W-1:1]}),
        .wdata (px2),
        .re    (en),
        .raddr ({rch, rrow[ROW_W-1:1], rcol[COL_W-1:1]}),
        .rdata (rd[r*2+c])
      );
    end
  end

  logic       act3, bad3;
  logic [1:0] x0p3, x1p3, y0p3, y1p3;
  logic [7:0] wx3, wy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act3 <= act2;
      bad3 <= !(32'(ch2) < MAX_CHANNELS);
      x0p3 <= {1'b0, x0_2[0]};
      x1p3 <= {1'b0, x1_2[0]};
      y0p3 <= {y0_2[0], 1'b0};
      y1p3 <= {y1_2[0], 1'b0};
      wx3  <= wx2;
      wy3  <= wy2;
    end
  end

  // Stage 4: horizontal blend.
  logic [7:0]  pa, pb, pc, pd;
  logic [16:0] top4, bot4;
  logic        bad4;
  logic [7:0]  wy4;

  always_comb begin
    pa = rd[y0p3 | x0p3];
    pb = rd[y0p3 | x1p3];
    pc = rd[y1p3 | x0p3];
    pd = rd[y1p3 | x1p3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3 && (act3 == ACTION_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top4 <= 17'(pa) * (17'd256 - 17'(wx3)) + 17'(pb) * 17'(wx3);
      bot4 <= 17'(pc) * (17'd256 - 17'(wx3)) + 17'(pd) * 17'(wx3);
      bad4 <= bad3;
      wy4  <= wy3;
    end
  end

  // Stage 5: vertical blend and rounding.
  logic [25:0] sum5;
  logic [25:0] rnd5;
  logic [7:0]  pix5;

  always_comb begin
    sum5 = 26'(top4) * (26'd256 - 26'(wy4)) + 26'(bot4) * 26'(wy4);
    rnd5 = sum5 + 26'd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (bad4) pix5 <= '0;
      else if (rnd5[25:24] != 2'd0) pix5 <= 8'hFF;
      else pix5 <= rnd5[23:16];
    end
  end

  assign rsp.valid     = v5;
  assign rsp.pixel_out = pix5;

endmodule

/* test/irs_sampler_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irs_sampler_checker
// Watches the register port and both channels of the image resize sampler.
// It keeps its own copy of the source image and the registers, predicts the
// output pixel of each sample request and compares it with the output stream.
// ----------------------------------------------------------------------------
module irs_sampler_checker
  import irs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  irs_req_if                    req,
  irs_rsp_if                    rsp,
  output int                    fail_count,
  output int                    pending
);

  logic [7:0]  src_image [MAX_CHANNELS*MAX_HEIGHT*MAX_WIDTH];
  logic        cur_mode;
  logic [8:0]  cur_width;
  logic [8:0]  cur_height;
  logic [23:0] cur_x_step;
  logic [23:0] cur_y_step;
  logic [7:0]  expected_pixels [$];

  function automatic longint eff_size(logic [8:0] v, int max_v);
    if (v == 0) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  function automatic longint clamp(longint i, longint size);
    if (i < 0) return 0;
    if (i >= size) return size - 1;
    return i;
  endfunction

  function automatic longint src_pos(logic [11:0] d, logic [23:0] step);
    return (2 * longint'(d) + 1) * longint'(step) - 65536;
  endfunction

  function automatic longint nearest_idx(longint p, longint size);
    if (p < 0) return 0;
    return clamp((p + 65536) >>> 17, size);
  endfunction

  function automatic longint floor_idx(longint p);
    return (p < 0) ? -1 : (p >>> 17);
  endfunction

  function automatic int frac_weight(longint p);
    longint f;
    f = floor_idx(p);
    return int'(((p - f * 131072) >>> 9) & 255);
  endfunction

  function automatic int pix(int ch, longint x, longint y);
    return src_image[(ch * MAX_HEIGHT + int'(y)) * MAX_WIDTH + int'(x)];
  endfunction

  function automatic logic [7:0] resample(logic [1:0] ch, logic [11:0] dx,
                                          logic [11:0] dy);
    longint w, h, px, py, x0, x1, y0, y1;
    int wx, wy, c;
    int unsigned upper, lower, sum, r;
    if (ch >= MAX_CHANNELS) return 8'd0;
    c = ch;
    w = eff_size(cur_width, MAX_WIDTH);
    h = eff_size(cur_height, MAX_HEIGHT);
    px = src_pos(dx, cur_x_step);
    py = src_pos(dy, cur_y_step);
    if (cur_mode == MODE_NEAREST) return 8'(pix(c, nearest_idx(px, w), nearest_idx(py, h)));
    wx = frac_weight(px);
    wy = frac_weight(py);
    x0 = clamp(floor_idx(px), w);
    x1 = clamp(floor_idx(px) + 1, w);
    y0 = clamp(floor_idx(py), h);
    y1 = clamp(floor_idx(py) + 1, h);
    upper = pix(c, x0, y0) * (256 - wx) + pix(c, x1, y0) * wx;
    lower = pix(c, x0, y1) * (256 - wx) + pix(c, x1, y1) * wx;
    sum = upper * (256 - wy) + lower * wy;
    r = (sum + 32768) >> 16;
    return (r > 255) ? 8'd255 : 8'(r);
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    if (rst) begin
      cur_mode   <= 1'b1;
      cur_width  <= 9'd256;
      cur_height <= 9'd256;
      cur_x_step <= 24'd65536;
      cur_y_step <= 24'd65536;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:       cur_mode   <= cfg_data[0];
          REG_SRC_WIDTH:  cur_width  <= cfg_data[8:0];
          REG_SRC_HEIGHT: cur_height <= cfg_data[8:0];
          REG_X_STEP:     cur_x_step <= cfg_data;
          REG_Y_STEP:     cur_y_step <= cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.action == ACTION_LOAD) begin
          if (req.coord_x < MAX_WIDTH && req.coord_y < MAX_HEIGHT &&
              req.channel < MAX_CHANNELS) begin
            src_image[(int'(req.channel) * MAX_HEIGHT + int'(req.coord_y)) * MAX_WIDTH
                      + int'(req.coord_x)] = req.pixel_in;
          end
        end else begin
          expected_pixels.push_back(resample(req.channel, req.coord_x, req.coord_y));
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel_out: no result expected, got %0d", rsp.pixel_out);
          fail_count <= fail_count + 1;
        end else begin
          if (rsp.pixel_out !== expected_pixels[0]) begin
            $error("pixel_out: expected %0d, got %0d", expected_pixels[0], rsp.pixel_out);
            fail_count <= fail_count + 1;
          end
          void'(expected_pixels.pop_front());
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

/* test/image_resize_sampler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_resize_sampler_tb
// Loads a source image region, then sends random sample and load requests
// under several register settings, with and without random stalls on both channels; the
// checker predicts every output pixel and counts mismatches.
// ----------------------------------------------------------------------------
module image_resize_sampler_tb;
  import irs_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    send_idle = 38;
  int                    recv_stall = 86;
  int                    quiet_cycles = 0;
  logic                  req_took = 1'b0;

  irs_req_if req ();
  irs_rsp_if rsp ();

  image_resize_sampler dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .rsp(rsp)
  );

  irs_sampler_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .rsp(rsp), .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.action = ACTION_LOAD;
    req.coord_x = '0;
    req.coord_y = '0;
    req.channel = '0;
    req.pixel_in = '0;
    rsp.ready = 1'b0;
  end

  always @(negedge clk) rsp.ready = ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    req_took <= req.valid && req.ready;
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 2000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_request(logic act, logic [11:0] x, logic [11:0] y, logic [1:0] ch,
                              logic [7:0] p);
    while ($urandom_range(99) < send_idle) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.action = act;
    req.coord_x = x;
    req.coord_y = y;
    req.channel = ch;
    req.pixel_in = p;
    do @(negedge clk); while (!req_took);
  endtask

  task automatic write_reg(irs_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [11:0] pick_coord(int size);
    if ($urandom_range(9) < 6) return 12'($urandom_range(0, 2 * size + 2));
    if ($urandom_range(9) == 0) return ($urandom_range(1) != 0) ? 12'd4095 : 12'd0;
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic run_setting(logic m, int w_raw, int h_raw, int xs, int ys, int count);
    int ew, eh;
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    write_reg(REG_MODE, 24'(m));
    write_reg(REG_SRC_WIDTH, 24'(w_raw));
    write_reg(REG_SRC_HEIGHT, 24'(h_raw));
    write_reg(REG_X_STEP, 24'(xs));
    write_reg(REG_Y_STEP, 24'(ys));
    ew = (w_raw == 0) ? 1 : (w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw;
    eh = (h_raw == 0) ? 1 : (h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw;
    for (int c = 0; c < MAX_CHANNELS; c++)
      for (int y = 0; y < eh; y++)
        for (int x = 0; x < ew; x++)
          send_request(ACTION_LOAD, 12'(x), 12'(y), 2'(c), 8'($urandom_range(0, 255)));
    repeat (count) begin
      if ($urandom_range(99) < 75) begin
        send_request(ACTION_SAMPLE, pick_coord(ew), pick_coord(eh),
                     ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                     8'($urandom_range(0, 255)));
      end else begin
        send_request(ACTION_LOAD, pick_coord(ew), pick_coord(eh),
                     2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_setting(MODE_NEAREST, 0, 1, 0, 0, 0);
    send_request(ACTION_SAMPLE, 12'd0, 12'd0, 2'd0, 8'd0);
    send_request(ACTION_SAMPLE, 12'd4095, 12'd4095, 2'd2, 8'd255);
    send_request(ACTION_SAMPLE, 12'd0, 12'd4095, 2'd1, 8'd0);
    send_request(ACTION_SAMPLE, 12'd5, 12'd5, 2'd3, 8'd0);
    send_request(ACTION_LOAD, 12'd4095, 12'd0, 2'd0, 8'd17);
    send_request(ACTION_LOAD, 12'd0, 12'd300, 2'd0, 8'd33);
    send_request(ACTION_LOAD, 12'd0, 12'd0, 2'd3, 8'd99);
    send_request(ACTION_LOAD, 12'd0, 12'd0, 2'd1, 8'd255);
    send_request(ACTION_SAMPLE, 12'd0, 12'd0, 2'd1, 8'd0);
    send_request(ACTION_LOAD, 12'd255, 12'd255, 2'd2, 8'd0);
    send_request(ACTION_SAMPLE, 12'd2047, 12'd1, 2'd2, 8'd0);
    run_setting(1'b1, 5, 3, 'h8000, 'h18000, 150);
    run_setting(MODE_NEAREST, 7, 6, 'h1C000, 'hC000, 150);

    send_idle = 86;
    recv_stall = 38;
    run_setting(1'b1, 20, 1, $urandom_range(0, 'hFFFFFF), 'hFFFFFF, 120);
    run_setting(MODE_NEAREST, 1, 40, 1, $urandom_range(0, 'h3FFFF), 120);

    send_idle = 0;
    recv_stall = 0;
    run_setting(1'b1, 9, 2, $urandom_range(0, 'h3FFFF), $urandom_range(0, 'h3FFFF), 150);
    run_setting(1'b1, 3, 8, 'hFFFFFF, 1, 100);

    req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
